/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clk_i edge outside reset
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

/* hw/rtl/pmms_pkg.sv */
// Types and constants of the pixel statistics block
package pmms_pkg;

  localparam int PIX_W    = 16;
  localparam int COORD_W  = 12;
  localparam int SUM_W    = 41;
  localparam int CNT_W    = 25;
  localparam int MEAN_W   = 17;
  localparam int MIN_W    = 18;
  localparam int MAX_W    = 17;
  localparam int IN_W     = 40;
  localparam int OUT_W    = 168;
  localparam int DIV_CW   = $clog2(SUM_W + 1);

  localparam logic signed [MIN_W-1:0] MIN_EMPTY = 18'sd65536;
  localparam logic signed [MIN_W-1:0] MAX_EMPTY = -18'sd32769;

  typedef enum logic [1:0] {
    ST_ACC,
    ST_START,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic take;       // input request accepted this cycle
    logic div_start;
    logic load_out;   // move result to output register, clear frame
  } cmd_t;

  typedef struct packed {
    logic div_busy;
  } sts_t;

endpackage

/* hw/rtl/pmms_div.sv */
// Restoring divider, one quotient bit per cycle, signed dividend
module pmms_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [pmms_pkg::SUM_W-1:0]   dividend_i,
  input  logic        [pmms_pkg::CNT_W-1:0]   divisor_i,
  output logic                                busy_o,
  output logic signed [pmms_pkg::MEAN_W-1:0]  quot_o
);
  import pmms_pkg::*;

  logic              busy_q, busy_d;
  logic [DIV_CW-1:0] cnt_q, cnt_d;
  logic [SUM_W-1:0]  quo_q, quo_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  dvs_q, dvs_d;
  logic              neg_q, neg_d;
  logic              zero_q, zero_d;
  logic [CNT_W:0]    rem_sh;
  logic [CNT_W+1:0]  diff;
  logic [SUM_W-1:0]  mag_in;
  logic [SUM_W-1:0]  quo_signed;

  assign mag_in = dividend_i[SUM_W-1] ? SUM_W'(-dividend_i) : SUM_W'(dividend_i);
  assign rem_sh = {rem_q, quo_q[SUM_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    zero_d = zero_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CW'(SUM_W);
      quo_d  = mag_in;
      rem_d  = '0;
      dvs_d  = divisor_i;
      neg_d  = dividend_i[SUM_W-1];
      zero_d = (divisor_i == '0);
    end else if (busy_q) begin
      if (!diff[CNT_W+1]) begin
        rem_d = diff[CNT_W-1:0];
        quo_d = {quo_q[SUM_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[CNT_W-1:0];
        quo_d = {quo_q[SUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_CW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    neg_q  <= neg_d;
    zero_q <= zero_d;
  end

  // truncation toward zero falls out of dividing magnitudes
  assign quo_signed = neg_q ? (~quo_q + 1'b1) : quo_q;
  assign quot_o     = zero_q ? '0 : $signed(quo_signed[MEAN_W-1:0]);
  assign busy_o     = busy_q;

endmodule

/* hw/rtl/pmms_dp.sv */
// Datapath: accumulators, min/max tracking, divider and result register
module pmms_dp #(
  parameter int MAX_PIXELS = 16777216,
  parameter int COORD_BITS = 12,
  parameter int PIXEL_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pmms_pkg::cmd_t                cmd_i,
  output pmms_pkg::sts_t                sts_o,
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  input  logic [pmms_pkg::IN_W-1:0]     in_data_i,
  input  logic                          in_none_i,
  output logic [pmms_pkg::OUT_W-1:0]    out_data_o
);
  import pmms_pkg::*;

  localparam int CB       = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
  localparam int CMASK    = (1 << CB) - 1;
  localparam int PMASK    = (1 << PIXEL_BITS) - 1;
  localparam int PIX_SPAN = 1 << PIXEL_BITS;

  logic                     mode_q;
  logic signed [SUM_W-1:0]  sum_q, sum_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic signed [MIN_W-1:0]  min_q, min_d, max_q, max_d;
  logic [COORD_W-1:0]       min_col_q, min_col_d, min_row_q, min_row_d;
  logic [COORD_W-1:0]       max_col_q, max_col_d, max_row_q, max_row_d;
  logic                     ovf_q, ovf_d;
  logic [OUT_W-1:0]         out_q;

  logic [PIX_W-1:0]         pix_raw;
  logic                     pix_neg;
  logic signed [MIN_W-1:0]  pix_val;
  logic [COORD_W-1:0]       col, row;
  logic                     has_pix, room;
  logic signed [MEAN_W-1:0] mean;

  assign pix_raw = in_data_i[PIX_W-1:0] & PIX_W'(PMASK);
  assign pix_neg = mode_q & pix_raw[PIXEL_BITS-1];
  assign pix_val = $signed(MIN_W'(pix_raw)) - (pix_neg ? MIN_W'(PIX_SPAN) : '0);
  assign col     = in_data_i[PIX_W +: COORD_W] & COORD_W'(CMASK);
  assign row     = in_data_i[PIX_W+COORD_W +: COORD_W] & COORD_W'(CMASK);
  assign has_pix = cmd_i.take & !in_none_i;
  assign room    = cnt_q < CNT_W'(MAX_PIXELS);

  always_comb begin
    sum_d     = sum_q;
    cnt_d     = cnt_q;
    min_d     = min_q;
    min_col_d = min_col_q;
    min_row_d = min_row_q;
    max_d     = max_q;
    max_col_d = max_col_q;
    max_row_d = max_row_q;
    ovf_d     = ovf_q;
    if (cmd_i.load_out) begin
      sum_d     = '0;
      cnt_d     = '0;
      min_d     = MIN_EMPTY;
      min_col_d = '0;
      min_row_d = '0;
      max_d     = MAX_EMPTY;
      max_col_d = '0;
      max_row_d = '0;
      ovf_d     = 1'b0;
    end else if (has_pix) begin
      if (!room) begin
        ovf_d = 1'b1;
      end else begin
        sum_d = sum_q + SUM_W'(pix_val);
        cnt_d = cnt_q + 1'b1;
        // strict compares keep the first location on ties
        if (pix_val < min_q) begin
          min_d     = pix_val;
          min_col_d = col;
          min_row_d = row;
        end
        if (pix_val > max_q) begin
          max_d     = pix_val;
          max_col_d = col;
          max_row_d = row;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= 1'b0;
      sum_q     <= '0;
      cnt_q     <= '0;
      min_q     <= MIN_EMPTY;
      min_col_q <= '0;
      min_row_q <= '0;
      max_q     <= MAX_EMPTY;
      max_col_q <= '0;
      max_row_q <= '0;
      ovf_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      sum_q     <= sum_d;
      cnt_q     <= cnt_d;
      min_q     <= min_d;
      min_col_q <= min_col_d;
      min_row_q <= min_row_d;
      max_q     <= max_d;
      max_col_q <= max_col_d;
      max_row_q <= max_row_d;
      ovf_q     <= ovf_d;
    end
  end

  pmms_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (sum_q),
    .divisor_i  (cnt_q),
    .busy_o     (sts_o.div_busy),
    .quot_o     (mean)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q <= {1'b0, ovf_q, cnt_q, max_row_q, max_col_q, max_q[MAX_W-1:0],
                min_row_q, min_col_q, min_q, mean, sum_q};
    end
  end

  assign out_data_o = out_q;

endmodule

/* hw/rtl/pmms_ctrl.sv */
// Controller: stream handshakes and sequencing of the end-of-frame divide
module pmms_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_last_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output pmms_pkg::cmd_t  cmd_o,
  input  pmms_pkg::sts_t  sts_i
);
  import pmms_pkg::*;

  state_e state_q, state_d;
  logic   ovalid_q, ovalid_d;
  logic   out_free;

  assign out_free = !ovalid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_ACC: begin
        if (in_valid_i && in_last_i) begin
          state_d = ST_START;
        end
      end
      ST_START: state_d = ST_DIV;
      ST_DIV: begin
        if (!sts_i.div_busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_ACC;
        end
      end
      default: state_d = ST_ACC;
    endcase
  end

  always_comb begin
    in_ready_o      = 1'b0;
    cmd_o.take      = 1'b0;
    cmd_o.div_start = 1'b0;
    cmd_o.load_out  = 1'b0;
    case (state_q)
      ST_ACC: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
      end
      ST_START: cmd_o.div_start = 1'b1;
      ST_DIV:   ;
      ST_DONE:  cmd_o.load_out = out_free;
      default:  ;
    endcase
  end

  always_comb begin
    ovalid_d = ovalid_q;
    if (cmd_o.load_out) begin
      ovalid_d = 1'b1;
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_ACC;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign out_valid_o = ovalid_q;

endmodule

/* hw/rtl/pixel_min_max_sum_stats.sv */
// Top level of the frame pixel statistics block
//
//  channel  dir  handshake              payload
//  s_axis   in   tvalid/tready          tdata: pixel, col, row; tlast: last; tuser: no_pixel
//  m_axis   out  tvalid/tready          tdata: total .. overflow
//  cfg      in   cfg_we_i               cfg_wdata_i: signed_mode
//
// Pixels are taken one per cycle while no frame end is being handled. The request
// marked last ends the frame: the divider for the mean runs and its result is loaded
// into the output register before the next request is taken. A result waiting
// in the output register does not stop pixels; only the next frame end waits for
// it to drain. Reset clears the frame state and the mode to unsigned.
`include "assert_macros.svh"

module pixel_min_max_sum_stats #(
  parameter int MAX_PIXELS = 16777216,
  parameter int COORD_BITS = 12,
  parameter int PIXEL_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // pixel[15:0], col[27:16], row[39:28]
  input  logic [pmms_pkg::IN_W-1:0]     s_axis_tdata,
  input  logic                          s_axis_tlast,
  // no_pixel
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // total[40:0], mean[57:41], min_value[75:58], min_col[87:76],
  // min_row[99:88], max_value[116:100], max_col[128:117],
  // max_row[140:129], pixel_count[165:141], overflow[166], zero[167]
  output logic [pmms_pkg::OUT_W-1:0]    m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i
);
  import pmms_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pmms_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_last_i   (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  pmms_dp #(
    .MAX_PIXELS (MAX_PIXELS),
    .COORD_BITS (COORD_BITS),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .in_none_i   (s_axis_tuser),
    .out_data_o  (m_axis_tdata)
  );

  `ASSERT_NEVER(a_busy_ready, sts.div_busy && s_axis_tready, "request taken during divide")
  `ASSERT_PROP(a_load_free, cmd.load_out |-> (!m_axis_tvalid || m_axis_tready), "result overwritten")
  `ASSERT_PROP(a_last_stall, (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready, "no stall after frame end")

endmodule

/* dv/tb_pixel_min_max_sum_stats.sv */
// Self-checking testbench for the frame pixel statistics block
module tb_pixel_min_max_sum_stats;
  timeunit 1ns;
  timeprecision 1ps;

  import pmms_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 6;
  // pixel cap of the block, same as its default
  localparam int CAP_PIXELS   = 16777216;
  localparam int LONG_MIN     = 40;
  localparam int LONG_MAX     = 56;
  localparam int RANDOM_ITEMS = 760;
  localparam int PHASE_ITEMS  = 90;
  localparam int DRAIN_CYCLES = 50;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct {
    logic [PIX_W-1:0]   pixel;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               last;
    logic               no_pixel;
  } pix_req_t;

  // packed in the order of the output bus, msb first
  typedef struct packed {
    logic               pad;
    logic               overflow;
    logic [CNT_W-1:0]   pixel_count;
    logic [COORD_W-1:0] max_row;
    logic [COORD_W-1:0] max_col;
    logic [MAX_W-1:0]   max_value;
    logic [COORD_W-1:0] min_row;
    logic [COORD_W-1:0] min_col;
    logic [MIN_W-1:0]   min_value;
    logic [MEAN_W-1:0]  mean;
    logic [SUM_W-1:0]   total;
  } frame_stats_t;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata  = '0;
  logic             s_axis_tlast  = 1'b0;
  logic             s_axis_tuser  = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic             cfg_we_i      = 1'b0;
  logic             cfg_wdata_i   = 1'b0;

  pix_req_t     pix_queue[$];
  frame_stats_t frame_stats_q[$];
  pix_req_t     cur_req;

  // predictor state
  bit                 mode_signed = 1'b0;
  longint             run_sum;
  longint             run_count;
  longint             low_val;
  longint             high_val;
  logic [COORD_W-1:0] low_col;
  logic [COORD_W-1:0] low_row;
  logic [COORD_W-1:0] high_col;
  logic [COORD_W-1:0] high_row;
  bit                 capped;

  int mismatches    = 0;
  int cycle_count   = 0;
  int idle_pct      = 10;
  int hold_requests = 0;
  int holds_done    = 0;
  int hold_left     = 0;

  pixel_min_max_sum_stats #(
    .MAX_PIXELS(CAP_PIXELS)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic void restart_frame();
    run_sum   = 0;
    run_count = 0;
    low_val   = longint'(MIN_EMPTY);
    high_val  = longint'(MAX_EMPTY);
    low_col   = '0;
    low_row   = '0;
    high_col  = '0;
    high_row  = '0;
    capped    = 1'b0;
  endfunction

  // Fold one accepted request into the running stats; a last request closes the frame.
  function automatic void accumulate_pixel(pix_req_t r);
    longint       v;
    longint       avg;
    frame_stats_t res;
    if (!r.no_pixel) begin
      if (run_count >= CAP_PIXELS) begin
        capped = 1'b1;
      end else begin
        v = mode_signed ? longint'($signed(r.pixel)) : longint'(r.pixel);
        run_sum += v;
        run_count++;
        // strict compares: ties keep the first place
        if (v < low_val) begin
          low_val = v;
          low_col = r.col;
          low_row = r.row;
        end
        if (v > high_val) begin
          high_val = v;
          high_col = r.col;
          high_row = r.row;
        end
      end
    end
    if (r.last) begin
      avg = (run_count != 0) ? run_sum / run_count : 0;
      res             = '0;
      res.total       = run_sum[SUM_W-1:0];
      res.mean        = avg[MEAN_W-1:0];
      res.min_value   = low_val[MIN_W-1:0];
      res.min_col     = low_col;
      res.min_row     = low_row;
      res.max_value   = high_val[MAX_W-1:0];
      res.max_col     = high_col;
      res.max_row     = high_row;
      res.pixel_count = run_count[CNT_W-1:0];
      res.overflow    = capped;
      frame_stats_q.push_back(res);
      restart_frame();
    end
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
  endtask

  // Request driver
  always @(posedge clk_i or negedge rst_ni) begin : drive_pixels
    bit offer;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
      s_axis_tuser  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        accumulate_pixel(cur_req);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        offer = (pix_queue.size() != 0) && ($urandom_range(99) >= idle_pct);
        if (offer) begin
          cur_req = pix_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {cur_req.row, cur_req.col, cur_req.pixel};
          s_axis_tlast  <= cur_req.last;
          s_axis_tuser  <= cur_req.no_pixel;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: random stalls plus the long hold-off when asked
  always @(posedge clk_i or negedge rst_ni) begin : drain_results
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (holds_done != hold_requests) begin
        holds_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    frame_stats_t got;
    frame_stats_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (frame_stats_q.size() == 0) begin
        report_mismatch("unexpected result", got.total, '0);
      end else begin
        want = frame_stats_q.pop_front();
        if (got.total !== want.total) report_mismatch("total", got.total, want.total);
        if (got.mean !== want.mean) report_mismatch("mean", got.mean, want.mean);
        if (got.min_value !== want.min_value) begin
          report_mismatch("min_value", got.min_value, want.min_value);
        end
        if (got.min_col !== want.min_col) report_mismatch("min_col", got.min_col, want.min_col);
        if (got.min_row !== want.min_row) report_mismatch("min_row", got.min_row, want.min_row);
        if (got.max_value !== want.max_value) begin
          report_mismatch("max_value", got.max_value, want.max_value);
        end
        if (got.max_col !== want.max_col) report_mismatch("max_col", got.max_col, want.max_col);
        if (got.max_row !== want.max_row) report_mismatch("max_row", got.max_row, want.max_row);
        if (got.pixel_count !== want.pixel_count) begin
          report_mismatch("pixel_count", got.pixel_count, want.pixel_count);
        end
        if (got.overflow !== want.overflow) begin
          report_mismatch("overflow", got.overflow, want.overflow);
        end
        if (got.pad !== 1'b0) report_mismatch("pad bit", got.pad, '0);
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_pixel_min_max_sum_stats NOT OK");
      $finish;
    end
  end

  function automatic void push_pixel(logic [PIX_W-1:0] pix, logic [COORD_W-1:0] col,
                                     logic [COORD_W-1:0] row, logic last);
    pix_req_t r;
    r.pixel    = pix;
    r.col      = col;
    r.row      = row;
    r.last     = last;
    r.no_pixel = 1'b0;
    pix_queue.push_back(r);
  endfunction

  // request with no pixel; random payload bits since the block must ignore them
  function automatic void push_close(logic last);
    pix_req_t r;
    r.pixel    = PIX_W'($urandom);
    r.col      = COORD_W'($urandom);
    r.row      = COORD_W'($urandom);
    r.last     = last;
    r.no_pixel = 1'b1;
    pix_queue.push_back(r);
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      3:       return 16'h7FFF;
      4, 5:    return PIX_W'($urandom_range(3));  // narrow set to force ties
      default: return PIX_W'($urandom);
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return COORD_W'($urandom);
    endcase
  endfunction

  function automatic int frame_size();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 0;
    if (r < 12) return $urandom_range(LONG_MIN, LONG_MAX);
    return $urandom_range(1, 24);
  endfunction

  // Queue one frame of n pixels; returns the number of requests queued.
  function automatic int add_frame(int n);
    bit tail_close;
    int queued;
    tail_close = (n == 0) || ($urandom_range(1) == 1);
    queued     = n + int'(tail_close);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(19) == 0) begin
        push_close(1'b0);
        queued++;
      end
      push_pixel(rand_pixel(), rand_coord(), rand_coord(), !tail_close && (i == n - 1));
    end
    if (tail_close) push_close(1'b1);
    return queued;
  endfunction

  // Wait until every request went in and every result came out.
  task automatic settle();
    do @(negedge clk_i);
    while (pix_queue.size() != 0 || s_axis_tvalid || frame_stats_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_mode(bit m);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    mode_signed = m;
    @(negedge clk_i);
  endtask

  initial begin : stimulus
    int counted;
    int phase_items;
    int ph;
    restart_frame();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    write_mode(1'b0);

    // unsigned: empty frame, ignored request, extremes, ties, frame closed by empty request
    push_close(1'b1);
    push_close(1'b0);
    push_pixel(16'h0000, 12'd0, 12'd0, 1'b0);
    push_pixel(16'hFFFF, 12'hFFF, 12'hFFF, 1'b0);
    push_pixel(16'h0000, 12'd5, 12'd6, 1'b0);
    push_pixel(16'hFFFF, 12'd7, 12'd8, 1'b0);
    push_close(1'b1);
    push_pixel(16'h8000, 12'hFFF, 12'd0, 1'b1);
    push_pixel(16'h0001, 12'd1, 12'd2, 1'b0);
    push_pixel(16'h0002, 12'd3, 12'd4, 1'b0);
    push_pixel(16'h0003, 12'd0, 12'hFFF, 1'b1);
    settle();

    // signed: most negative and most positive, ties, empty frame
    write_mode(1'b1);
    push_pixel(16'h8000, 12'd10, 12'd20, 1'b0);
    push_pixel(16'h7FFF, 12'd30, 12'd40, 1'b0);
    push_pixel(16'hFFFF, 12'd50, 12'd60, 1'b0);
    push_pixel(16'h8000, 12'd1, 12'd1, 1'b0);
    push_pixel(16'h7FFF, 12'd2, 12'd2, 1'b1);
    push_close(1'b1);
    push_pixel(16'hFFF0, 12'd3, 12'd3, 1'b1);
    // frame left open across a mode change
    push_pixel(16'hFFFF, 12'd11, 12'd12, 1'b0);
    push_pixel(16'h8001, 12'd13, 12'd14, 1'b0);
    settle();
    write_mode(1'b0);
    push_pixel(16'hFFFF, 12'd15, 12'd16, 1'b1);
    settle();

    counted = 0;
    ph = 0;
    while (counted < RANDOM_ITEMS) begin
      idle_pct = (ph == 2) ? 0 : 10;
      // long receiver hold-off over a run of short frames fills the block up
      if (ph == 4) hold_requests++;
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        phase_items += add_frame((ph == 4) ? $urandom_range(1, 3) : frame_size());
      end
      // sometimes leave a frame open so the next mode applies mid-frame
      if ($urandom_range(9) < 3) begin
        for (int i = $urandom_range(1, 6); i > 0; i--) begin
          push_pixel(rand_pixel(), rand_coord(), rand_coord(), 1'b0);
          phase_items++;
        end
      end
      counted += phase_items;
      settle();
      write_mode(1'($urandom_range(1)));
      ph++;
    end
    // close any frame still open
    push_close(1'b1);
    settle();

    if (mismatches == 0) begin
      $display("tb_pixel_min_max_sum_stats OK");
    end else begin
      $display("tb_pixel_min_max_sum_stats NOT OK");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/pmms_pkg.sv
hw/rtl/pmms_div.sv
hw/rtl/pmms_dp.sv
hw/rtl/pmms_ctrl.sv
hw/rtl/pixel_min_max_sum_stats.sv
dv/tb_pixel_min_max_sum_stats.sv
